// ===== rtl/core/lpcd_pkg.sv =====
// Package: shared constants, commands and status codes of the page cache directory.
`default_nettype none
package lpcd_pkg;
  localparam int SLOTS_DEF = 32;
  localparam int PAGE_W = 31;
  localparam int CMD_W = 3;
  localparam int SLOT_W = 5;
  localparam int STAT_W = 2;
  localparam int CNT_W = 6;

  localparam logic [CMD_W-1:0] CMD_READ = 3'd0;
  localparam logic [CMD_W-1:0] CMD_LOOKUP = 3'd1;
  localparam logic [CMD_W-1:0] CMD_DIRTY = 3'd2;
  localparam logic [CMD_W-1:0] CMD_NEW = 3'd3;
  localparam logic [CMD_W-1:0] CMD_INVAL = 3'd4;
  localparam logic [CMD_W-1:0] CMD_DISCARD = 3'd5;
  localparam logic [CMD_W-1:0] CMD_FLUSH = 3'd6;

  localparam logic [STAT_W-1:0] ST_OK = 2'd0;
  localparam logic [STAT_W-1:0] ST_WFAIL = 2'd1;
  localparam logic [STAT_W-1:0] ST_NOSLOT = 2'd2;

  typedef struct packed {
    logic [CMD_W-1:0] command;
    logic [PAGE_W-1:0] page_number;
    logic force_req;
    logic flush_ok;
  } req_t;

  typedef struct packed {
    logic hit;
    logic [SLOT_W-1:0] slot;
    logic [STAT_W-1:0] status;
    logic wrote_back;
    logic [PAGE_W-1:0] written_page;
    logic [CNT_W-1:0] flushed_count;
    logic last;
  } rsp_t;
endpackage
`default_nettype wire

// ===== rtl/core/lpcd_if.sv =====
// Interfaces: request and response channels with valid/ready handshake.
`default_nettype none
interface lpcd_req_if;
  import lpcd_pkg::*;
  logic valid;
  logic ready;
  req_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface lpcd_rsp_if;
  import lpcd_pkg::*;
  logic valid;
  logic ready;
  rsp_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/lpcd_cell.sv =====
// Cell: one directory slot with tag, valid, dirty, recency rank and free-list entry.
`default_nettype none
module lpcd_cell #(
  parameter int RW = 6
) (
  input wire logic clk,
  input wire logic rst,
  input wire logic [lpcd_pkg::PAGE_W-1:0] cmp_page,
  input wire logic sel,
  input wire logic op_touch,
  input wire logic op_link,
  input wire logic op_unlink,
  input wire logic [RW-1:0] ref_rank,
  input wire logic set_page,
  input wire logic set_dirty,
  input wire logic clr_dirty,
  input wire logic discard,
  input wire logic [RW-1:0] free_in,
  input wire logic free_shift,
  input wire logic free_load,
  input wire logic [RW-1:0] free_val,
  output logic match,
  output logic valid,
  output logic dirty,
  output logic [RW-1:0] rank,
  output logic [lpcd_pkg::PAGE_W-1:0] page,
  output logic [RW-1:0] free_out
);
  import lpcd_pkg::*;
  assign match = valid && page == cmp_page;
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      dirty <= 1'b0;
    end else begin
      if (sel && set_page) page <= cmp_page;
      if (free_load) free_out <= free_val;
      else if (free_shift) free_out <= free_in;
      if (op_touch) begin
        if (sel) rank <= '0;
        else if (valid && rank < ref_rank) rank <= rank + 1'b1;
      end
      if (op_link) begin
        if (sel) begin
          rank <= '0;
          valid <= 1'b1;
        end else if (valid) rank <= rank + 1'b1;
      end
      if (op_unlink) begin
        if (sel) valid <= 1'b0;
        else if (valid && rank > ref_rank) rank <= rank - 1'b1;
      end
      if (sel && set_dirty) dirty <= 1'b1;
      else if (sel && clr_dirty) dirty <= 1'b0;
      else if (discard && valid && page >= cmp_page) dirty <= 1'b0;
    end
  end
endmodule
`default_nettype wire

// ===== rtl/core/lru_page_cache_directory.sv =====
// Top level: page cache directory control around a row of slot cells.
// Most commands: accepted, executed, then the result is offered. A victim
// search walks the slots, one per cycle; flush all walks the slots, one per
// cycle unless a write-back word waits to be taken, giving each as it is found.
// One command at a time; the next is taken once the last result is taken.
// Synchronous reset empties the directory, free list and fill pointer.
`default_nettype none
module lru_page_cache_directory #(
  parameter int SLOTS = lpcd_pkg::SLOTS_DEF
) (
  input wire logic clk,
  input wire logic rst,
  input wire logic cfg_we,
  input wire logic cfg_wdata,
  lpcd_req_if.sink req,
  lpcd_rsp_if.source rsp
);
  import lpcd_pkg::*;
  localparam int IW = $clog2(SLOTS) > 0 ? $clog2(SLOTS) : 1;
  localparam int RW = $clog2(SLOTS + 1);

  localparam logic [3:0] S_IDLE = 4'd0, S_EXEC = 4'd1, S_SCAN = 4'd2, S_VICT = 4'd3,
    S_CLEAN = 4'd4, S_FIN = 4'd5, S_OUT = 4'd6, S_FLUSH = 4'd7, S_WBOUT = 4'd8;

  logic [3:0] state;
  logic wdef;
  req_t r;
  logic [IW-1:0] cur;
  logic [RW-1:0] fcnt, fill;
  logic [RW-1:0] scan;
  logic [IW-1:0] best;
  logic best_ok;
  logic clean_pass;
  logic [CNT_W-1:0] cnt;
  logic failed;
  logic [IW-1:0] tgt;
  rsp_t o;
  logic ret_state_flush;
  logic link_new;

  logic [SLOTS-1:0] match, vld, drt, sel;
  logic [RW-1:0] rk [SLOTS];
  logic [PAGE_W-1:0] pg [SLOTS];
  logic [RW-1:0] fo [SLOTS];
  logic op_touch, op_link, op_unlink, set_page, set_dirty, clr_dirty, disc;
  logic free_shift, free_load;
  logic [RW-1:0] ref_rank;
  logic [PAGE_W-1:0] cmp_page;

  logic hit;
  logic [IW-1:0] hidx;
  always_comb begin
    hit = |match;
    hidx = '0;
    for (int i = 0; i < SLOTS; i++) if (match[i]) hidx = IW'(i);
  end

  genvar g;
  generate
    for (g = 0; g < SLOTS; g++) begin : g_cell
      lpcd_cell #(.RW(RW)) u_cell (
        .clk, .rst, .cmp_page, .sel(sel[g]), .op_touch, .op_link, .op_unlink,
        .ref_rank, .set_page, .set_dirty, .clr_dirty, .discard(disc),
        .free_in(g + 1 < SLOTS ? fo[(g + 1) % SLOTS] : '0), .free_shift,
        .free_load(free_load && fcnt == RW'(g + 1)), .free_val(RW'(tgt)),
        .match(match[g]), .valid(vld[g]), .dirty(drt[g]), .rank(rk[g]),
        .page(pg[g]), .free_out(fo[g]));
    end
  endgenerate

  assign cmp_page = r.page_number;
  assign req.ready = state == S_IDLE;
  assign rsp.valid = state == S_OUT || state == S_WBOUT;
  assign rsp.data = o;

  logic [IW-1:0] sidx;
  assign sidx = scan[IW-1:0];

  always_comb begin
    sel = '0;
    sel[tgt] = 1'b1;
    ref_rank = rk[tgt];
  end

  function automatic rsp_t mk(logic h, logic [SLOT_W-1:0] s, logic [STAT_W-1:0] st,
                              logic wb, logic [PAGE_W-1:0] p, logic [CNT_W-1:0] c,
                              logic l);
    rsp_t x;
    x.hit = h; x.slot = s; x.status = st; x.wrote_back = wb;
    x.written_page = p; x.flushed_count = c; x.last = l;
    return x;
  endfunction

  always_ff @(posedge clk) begin
    op_touch <= 1'b0; op_link <= 1'b0; op_unlink <= 1'b0; set_page <= 1'b0;
    set_dirty <= 1'b0; clr_dirty <= 1'b0; disc <= 1'b0; free_shift <= 1'b0;
    free_load <= 1'b0;
    if (rst) begin
      state <= S_IDLE;
      wdef <= 1'b0;
      cur <= '0;
      fcnt <= '0;
      fill <= '0;
      link_new <= 1'b0;
    end else begin
      if (cfg_we) wdef <= cfg_wdata;
      case (state)
        S_IDLE: if (req.valid) begin
          r <= req.data;
          state <= S_EXEC;
        end
        S_EXEC: begin
          state <= S_OUT;
          o <= mk(1'b0, '0, ST_OK, 1'b0, '0, '0, 1'b1);
          case (r.command)
            CMD_READ, CMD_NEW: begin
              if (hit && r.command == CMD_READ) begin
                tgt <= hidx; op_touch <= 1'b1; cur <= hidx;
                o <= mk(1'b1, SLOT_W'(hidx), ST_OK, 1'b0, '0, '0, 1'b1);
              end else if (hit) begin
                tgt <= hidx;
                if (wdef) begin
                  set_dirty <= 1'b1;
                  o <= mk(1'b1, SLOT_W'(hidx), ST_OK, 1'b0, '0, '0, 1'b1);
                end else begin
                  if (r.flush_ok) clr_dirty <= 1'b1; else set_dirty <= 1'b1;
                  o <= mk(1'b1, SLOT_W'(hidx), r.flush_ok ? ST_OK : ST_WFAIL, 1'b1,
                          r.page_number, '0, 1'b1);
                end
              end else if (r.command == CMD_NEW && !wdef) begin
                o <= mk(1'b0, '0, r.flush_ok ? ST_OK : ST_WFAIL, 1'b1,
                        r.page_number, '0, 1'b1);
              end else if (fcnt != '0) begin
                tgt <= fo[0][IW-1:0];
                free_shift <= 1'b1;
                fcnt <= fcnt - 1'b1;
                if (vld[fo[0][IW-1:0]]) op_unlink <= 1'b1;
                link_new <= 1'b1;
                state <= S_FIN;
              end else if (fill < RW'(SLOTS)) begin
                tgt <= fill[IW-1:0];
                fill <= fill + 1'b1;
                link_new <= 1'b1;
                state <= S_FIN;
              end else begin
                scan <= '0; best_ok <= 1'b0; clean_pass <= 1'b0;
                link_new <= 1'b0;
                state <= S_SCAN;
              end
            end
            CMD_LOOKUP:
              o <= mk(hit, hit ? SLOT_W'(hidx) : '0, ST_OK, 1'b0, '0, '0, 1'b1);
            CMD_DIRTY: begin
              tgt <= cur;
              if (!vld[cur]) o <= mk(1'b0, SLOT_W'(cur), ST_OK, 1'b0, '0, '0, 1'b1);
              else if (wdef && !r.force_req) begin
                set_dirty <= 1'b1;
                o <= mk(1'b1, SLOT_W'(cur), ST_OK, 1'b0, '0, '0, 1'b1);
              end else begin
                clr_dirty <= r.flush_ok;
                o <= mk(1'b1, SLOT_W'(cur), r.flush_ok ? ST_OK : ST_WFAIL, 1'b1,
                        pg[cur], '0, 1'b1);
              end
            end
            CMD_INVAL: if (hit) begin
              tgt <= hidx; op_unlink <= 1'b1; clr_dirty <= 1'b1;
              if (fcnt < RW'(SLOTS)) begin
                free_load <= 1'b1; fcnt <= fcnt + 1'b1;
              end
              o <= mk(1'b1, SLOT_W'(hidx), ST_OK, 1'b0, '0, '0, 1'b1);
            end
            CMD_DISCARD: disc <= 1'b1;
            CMD_FLUSH: begin
              scan <= '0; cnt <= '0; failed <= 1'b0; state <= S_FLUSH;
            end
            default: ;
          endcase
        end
        S_SCAN: begin
          if (vld[sidx] && !(clean_pass && drt[sidx]) &&
              (!best_ok || rk[sidx] > rk[best])) begin
            best <= sidx; best_ok <= 1'b1;
          end
          if (scan == RW'(SLOTS - 1)) state <= S_VICT;
          else scan <= scan + 1'b1;
        end
        S_VICT: begin
          if (!best_ok) begin
            o <= mk(1'b0, '0, ST_NOSLOT, 1'b0, '0, '0, 1'b1);
            state <= S_OUT;
          end else begin
            tgt <= best; op_touch <= 1'b1;
            if (!clean_pass && drt[best]) begin
              o <= mk(1'b0, SLOT_W'(best), r.flush_ok ? ST_OK : ST_WFAIL, 1'b1,
                      pg[best], '0, 1'b0);
              ret_state_flush <= 1'b0;
              state <= S_WBOUT;
            end else state <= S_FIN;
          end
        end
        S_CLEAN: begin
          scan <= '0; best_ok <= 1'b0; clean_pass <= 1'b1; state <= S_SCAN;
        end
        S_FIN: begin
          set_page <= 1'b1;
          if (r.command == CMD_NEW) set_dirty <= 1'b1; else clr_dirty <= 1'b1;
          if (link_new) op_link <= 1'b1;
          if (r.command == CMD_READ) cur <= tgt;
          o <= mk(1'b0, SLOT_W'(tgt), ST_OK, 1'b0, '0, '0, 1'b1);
          state <= S_OUT;
        end
        S_FLUSH: begin
          if (vld[sidx] && drt[sidx]) begin
            tgt <= sidx; clr_dirty <= r.flush_ok;
            if (r.flush_ok) cnt <= cnt + 1'b1; else failed <= 1'b1;
            o <= mk(1'b0, SLOT_W'(sidx), r.flush_ok ? ST_OK : ST_WFAIL, 1'b1,
                    pg[sidx], '0, 1'b0);
            ret_state_flush <= 1'b1;
            state <= S_WBOUT;
          end else if (scan == RW'(SLOTS - 1)) begin
            o <= mk(1'b0, '0, failed ? ST_WFAIL : ST_OK, 1'b0, '0, cnt, 1'b1);
            state <= S_OUT;
          end else scan <= scan + 1'b1;
        end
        S_WBOUT: if (rsp.ready) begin
          if (ret_state_flush) begin
            if (scan == RW'(SLOTS - 1)) begin
              o <= mk(1'b0, '0, failed ? ST_WFAIL : ST_OK, 1'b0, '0, cnt, 1'b1);
              state <= S_OUT;
            end else begin
              scan <= scan + 1'b1; state <= S_FLUSH;
            end
          end else if (r.flush_ok) state <= S_FIN;
          else state <= S_CLEAN;
        end
        S_OUT: if (rsp.ready) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire
